[rtl/core/pidc_pkg.sv]
package pidc_pkg;

  localparam int ID_W       = 12;
  localparam int CHAN_W     = 9;
  localparam int OFS_W      = 24;
  localparam int DOMAIN_W   = 3;
  localparam int LIMIT_W    = 10;
  localparam int RESUME_W   = 10;
  localparam int BYTE_SHIFT = 12;

  localparam logic [LIMIT_W-1:0] SCAN_LIMIT_RESET = 10'd512;

  localparam logic CMD_WRITE  = 1'b0;
  localparam logic CMD_LOOKUP = 1'b1;

  localparam logic REG_SCAN_LIMIT    = 1'b0;
  localparam logic REG_ACTIVE_DOMAIN = 1'b1;

  localparam logic STATUS_OK        = 1'b0;
  localparam logic STATUS_NOT_FOUND = 1'b1;

  typedef struct packed {
    logic            used;
    logic [ID_W-1:0] id;
  } map_entry_t;

  typedef struct packed {
    logic              valid;
    logic [CHAN_W-1:0] chan;
  } cache_entry_t;

endpackage

[rtl/core/pidc_ram.sv]
module pidc_ram
  import pidc_pkg::*;
#(
  parameter int DEPTH = 512,
  parameter int WIDTH = 13
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    rdata <= mem[raddr];
  end

endmodule

[rtl/core/peripheral_id_to_channel_lookup.sv]
// a map write is answered in the cycle after its transfer, a cache hit from ST_LOOKUP;
// a lookup that misses the cache scans one map entry per cycle (map ram read port)
// one item at a time: the next item is taken once the previous result is transferred
// reset: synchronous, active low; a clearing pass over max(MAP_ENTRIES, ID_SPACE) addresses
// (4096 by default) zeroes the map and reverse cache, no item is taken meanwhile
module peripheral_id_to_channel_lookup
  import pidc_pkg::*;
#(
  parameter int MAP_ENTRIES = 512,
  parameter int ID_SPACE    = 4096
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_ready,
  input  logic                in_command,
  input  logic [8:0]          in_entry_index,
  input  logic [31:0]         in_entry_word,
  input  logic [3:0]          in_slave_id,
  input  logic [15:0]         in_reg_address,
  output logic                out_valid,
  input  logic                out_ready,
  output logic                out_status,
  output logic [CHAN_W-1:0]   out_channel,
  output logic [OFS_W-1:0]    out_channel_offset,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [2:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);

  localparam int MAW       = $clog2(MAP_ENTRIES);
  localparam int CAW       = $clog2(ID_SPACE);
  localparam int SCAN_W    = $clog2(MAP_ENTRIES + 1);
  localparam int CLR_DEPTH = (MAP_ENTRIES > ID_SPACE) ? MAP_ENTRIES : ID_SPACE;
  localparam int CLR_W     = $clog2(CLR_DEPTH);

  localparam logic [SCAN_W-1:0] MAP_LIM_S   = SCAN_W'(MAP_ENTRIES);
  localparam logic [CLR_W:0]    MAP_LIM_C   = (CLR_W + 1)'(MAP_ENTRIES);
  localparam logic [CLR_W:0]    ID_LIM_C    = (CLR_W + 1)'(ID_SPACE);
  localparam logic [CLR_W-1:0]  CLR_LAST    = CLR_W'(CLR_DEPTH - 1);
  localparam logic [ID_W:0]     ID_LIM      = (ID_W + 1)'(ID_SPACE);
  localparam logic [10:0]       IDX_LIM     = 11'(MAP_ENTRIES);

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_LOOKUP,
    ST_SCAN
  } state_t;

  state_t              state_r, state_nxt;
  logic [CLR_W-1:0]    clr_r, clr_nxt;
  logic [ID_W-1:0]     id_r, id_nxt;
  logic [SCAN_W-1:0]   e_r, e_nxt;
  logic [SCAN_W-1:0]   chk_r, chk_nxt;
  logic [RESUME_W-1:0] resume_r, resume_nxt;
  logic                out_valid_r, out_valid_nxt;
  logic                status_r, status_nxt;
  logic [CHAN_W-1:0]   chan_r, chan_nxt;
  logic [OFS_W-1:0]    ofs_r, ofs_nxt;

  logic [LIMIT_W-1:0]  scan_limit_r;
  logic [DOMAIN_W-1:0] domain_r;

  logic                map_we;
  logic [MAW-1:0]      map_waddr;
  map_entry_t          map_wdata;
  logic [MAW-1:0]      map_raddr;
  map_entry_t          map_rdata;
  logic                cache_we;
  logic [CAW-1:0]      cache_waddr;
  cache_entry_t        cache_wdata;
  logic [CAW-1:0]      cache_raddr;
  cache_entry_t        cache_rdata;

  logic                in_xfer;
  logic [ID_W-1:0]     id_in;
  logic [SCAN_W-1:0]   scan_pos;
  logic                in_bound;
  logic                reg_sel;

  assign in_ready = (state_r == ST_IDLE) && !out_valid_r;
  assign in_xfer  = in_valid && in_ready;
  assign id_in    = {in_slave_id, in_reg_address[15:8]};

  // scan starts at the kept resume point, then walks the local index
  assign scan_pos = (state_r == ST_LOOKUP) ? SCAN_W'(resume_r) : e_r;
  assign in_bound = (scan_pos < MAP_LIM_S) &&
                    ((LIMIT_W + 1)'(scan_pos) < (LIMIT_W + 1)'(scan_limit_r));

  pidc_ram #(
    .DEPTH (MAP_ENTRIES),
    .WIDTH ($bits(map_entry_t))
  ) u_map_ram (
    .clk   (clk),
    .we    (map_we),
    .waddr (map_waddr),
    .wdata (map_wdata),
    .raddr (map_raddr),
    .rdata (map_rdata)
  );

  pidc_ram #(
    .DEPTH (ID_SPACE),
    .WIDTH ($bits(cache_entry_t))
  ) u_cache_ram (
    .clk   (clk),
    .we    (cache_we),
    .waddr (cache_waddr),
    .wdata (cache_wdata),
    .raddr (cache_raddr),
    .rdata (cache_rdata)
  );

  always_comb begin
    state_nxt     = state_r;
    clr_nxt       = clr_r;
    id_nxt        = id_r;
    e_nxt         = e_r;
    chk_nxt       = chk_r;
    resume_nxt    = resume_r;
    out_valid_nxt = out_valid_r && !out_ready;
    status_nxt    = status_r;
    chan_nxt      = chan_r;
    ofs_nxt       = ofs_r;

    map_we        = 1'b0;
    map_waddr     = MAW'(in_entry_index);
    map_wdata     = '{used: (in_entry_word != 32'd0), id: in_entry_word[19:8]};
    map_raddr     = scan_pos[MAW-1:0];
    cache_we      = 1'b0;
    cache_waddr   = map_rdata.id[CAW-1:0];
    cache_wdata   = '{valid: 1'b1, chan: CHAN_W'(chk_r)};
    cache_raddr   = id_in[CAW-1:0];

    case (state_r)
      ST_CLEAR: begin
        map_we      = ({1'b0, clr_r} < MAP_LIM_C);
        map_waddr   = clr_r[MAW-1:0];
        map_wdata   = '0;
        cache_we    = ({1'b0, clr_r} < ID_LIM_C);
        cache_waddr = clr_r[CAW-1:0];
        cache_wdata = '0;
        if (clr_r == CLR_LAST) begin
          state_nxt = ST_IDLE;
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end
      ST_IDLE: begin
        if (in_xfer) begin
          if (in_command == CMD_WRITE) begin
            map_we        = ({2'b00, in_entry_index} < IDX_LIM);
            out_valid_nxt = 1'b1;
            status_nxt    = STATUS_OK;
            chan_nxt      = '0;
            ofs_nxt       = '0;
          end else begin
            id_nxt = id_in;
            if ({1'b0, id_in} < ID_LIM) begin
              state_nxt = ST_LOOKUP;
            end else begin
              out_valid_nxt = 1'b1;
              status_nxt    = STATUS_NOT_FOUND;
              chan_nxt      = '0;
              ofs_nxt       = '0;
            end
          end
        end
      end
      ST_LOOKUP: begin
        if (cache_rdata.valid) begin
          out_valid_nxt = 1'b1;
          status_nxt    = STATUS_OK;
          chan_nxt      = cache_rdata.chan;
          ofs_nxt       = {cache_rdata.chan, domain_r, BYTE_SHIFT'(0)};
          state_nxt     = ST_IDLE;
        end else if (in_bound) begin
          chk_nxt   = scan_pos;
          e_nxt     = scan_pos + 1'b1;
          state_nxt = ST_SCAN;
        end else begin
          out_valid_nxt = 1'b1;
          status_nxt    = STATUS_NOT_FOUND;
          chan_nxt      = '0;
          ofs_nxt       = '0;
          state_nxt     = ST_IDLE;
        end
      end
      ST_SCAN: begin
        // every nonzero entry visited whose id lies inside ID_SPACE lands in the reverse cache
        cache_we = map_rdata.used && ({1'b0, map_rdata.id} < ID_LIM);
        if (map_rdata.used && (map_rdata.id == id_r)) begin
          out_valid_nxt = 1'b1;
          status_nxt    = STATUS_OK;
          chan_nxt      = CHAN_W'(chk_r);
          ofs_nxt       = {CHAN_W'(chk_r), domain_r, BYTE_SHIFT'(0)};
          state_nxt     = ST_IDLE;
        end else if (in_bound) begin
          chk_nxt = scan_pos;
          e_nxt   = scan_pos + 1'b1;
        end else begin
          resume_nxt    = RESUME_W'(e_r);
          out_valid_nxt = 1'b1;
          status_nxt    = STATUS_NOT_FOUND;
          chan_nxt      = '0;
          ofs_nxt       = '0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_CLEAR;
        clr_nxt   = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      resume_r    <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      resume_r    <= resume_nxt;
      out_valid_r <= out_valid_nxt;
      id_r        <= id_nxt;
      e_r         <= e_nxt;
      chk_r       <= chk_nxt;
      status_r    <= status_nxt;
      chan_r      <= chan_nxt;
      ofs_r       <= ofs_nxt;
    end
  end

  assign out_valid          = out_valid_r;
  assign out_status         = status_r;
  assign out_channel        = chan_r;
  assign out_channel_offset = ofs_r;

  // configuration registers
  assign reg_sel = paddr[2];
  assign pready  = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_limit_r <= SCAN_LIMIT_RESET;
      domain_r     <= '0;
    end else if (psel && penable && pwrite) begin
      case (reg_sel)
        REG_SCAN_LIMIT:    scan_limit_r <= pwdata[LIMIT_W-1:0];
        REG_ACTIVE_DOMAIN: domain_r     <= pwdata[DOMAIN_W-1:0];
        default:           scan_limit_r <= scan_limit_r;
      endcase
    end
  end

  always_comb begin
    case (reg_sel)
      REG_SCAN_LIMIT:    prdata = 32'(scan_limit_r);
      REG_ACTIVE_DOMAIN: prdata = 32'(domain_r);
      default:           prdata = '0;
    endcase
  end

  a_write_answers: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_command == CMD_WRITE) |=> out_valid)
    else $error("map write transfer not answered next cycle");

  a_miss_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status == STATUS_NOT_FOUND) |->
      (out_channel == '0) && (out_channel_offset == '0))
    else $error("not-found result carries channel data");

  a_scan_in_map: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (chk_r < MAP_LIM_S))
    else $error("scan index outside the map");

  a_clear_blocks: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_CLEAR) |-> !out_valid && !in_ready)
    else $error("traffic during clearing pass");

endmodule
